### hw/rtl/ppc_pkg.sv
package ppc_pkg;

    // Sizes of the fixed-width state
    localparam int STEM_BUFFER_BYTES = 7;
    localparam int STEM_IDX_W        = $clog2(STEM_BUFFER_BYTES);
    localparam int STEM_LEN_W        = 4;
    localparam int COUNT_W           = 10;
    localparam int DEPTH_W           = 7;
    localparam int MAX_LEN_W         = 10;
    localparam int MAX_DEPTH_W       = 6;

    localparam logic [COUNT_W-1:0]     COUNT_MAX = 10'd1023;
    localparam logic [DEPTH_W-1:0]     DEPTH_MAX = 7'd64;
    localparam logic [STEM_LEN_W-1:0]  STEM_LEN_MAX = STEM_LEN_W'(STEM_BUFFER_BYTES);

    localparam logic [MAX_LEN_W-1:0]   MAX_LEN_RESET   = 10'd255;
    localparam logic [MAX_DEPTH_W-1:0] MAX_DEPTH_RESET = 6'd24;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COMPONENT_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH            = 2'd1;

    // Byte codes
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_LESS      = 8'h3C;
    localparam logic [7:0] CH_GREATER   = 8'h3E;
    localparam logic [7:0] CH_PIPE      = 8'h7C;
    localparam logic [7:0] CH_DIGIT_1   = 8'h31;
    localparam logic [7:0] CH_DIGIT_9   = 8'h39;

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_slash;
        logic       is_dot;
        logic       is_space;
        logic       is_forbidden;
    } ppc_item_t;

    // Configuration write
    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } ppc_cfg_wr_t;

    typedef logic [STEM_BUFFER_BYTES-1:0][7:0] stem_t;

    function automatic logic is_forbidden_byte(logic [7:0] b);
        return (b == CH_BACKSLASH) || (b == CH_COLON) || (b == CH_STAR) ||
               (b == CH_QUESTION) || (b == CH_QUOTE) || (b == CH_LESS) ||
               (b == CH_GREATER) || (b == CH_PIPE);
    endfunction

    // Reserved device names, case-sensitive, lower case
    function automatic logic stem_is_device(stem_t s, logic [STEM_LEN_W-1:0] len);
        logic [23:0] p3;
        logic        m;
        p3 = {s[0], s[1], s[2]};
        m  = 1'b0;
        case (len)
            4'd3: m = (p3 == "con") || (p3 == "prn") || (p3 == "aux") || (p3 == "nul");
            4'd4: m = ((p3 == "com") || (p3 == "lpt")) &&
                      (s[3] >= CH_DIGIT_1) && (s[3] <= CH_DIGIT_9);
            4'd6: m = ({p3, s[3], s[4], s[5]} == "conin$") ||
                      ({p3, s[3], s[4], s[5]} == "clock$");
            4'd7: m = ({p3, s[3], s[4], s[5], s[6]} == "conout$");
            default: m = 1'b0;
        endcase
        return m;
    endfunction

endpackage

### hw/rtl/ppc_front.sv
module ppc_front
    import ppc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  logic [7:0] path_byte,
    input  logic      last_byte,
    output logic      item_valid,
    output ppc_item_t item,
    input  logic      item_take
);

    // Two-entry queue of classified bytes
    ppc_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       in_fire, out_fire;
    ppc_item_t  cls;

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = mem_reg[rd_ptr_reg];
    assign in_fire    = push && !full;
    assign out_fire   = item_take && item_valid;

    // Classify the incoming byte
    always_comb
    begin
        cls.data         = path_byte;
        cls.last         = last_byte;
        cls.is_slash     = (path_byte == CH_SLASH);
        cls.is_dot       = (path_byte == CH_DOT);
        cls.is_space     = (path_byte == CH_SPACE);
        cls.is_forbidden = is_forbidden_byte(path_byte);
    end

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = in_fire  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = out_fire ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        case ({in_fire, out_fire})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

### hw/rtl/ppc_back.sv
module ppc_back
    import ppc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ppc_cfg_wr_t cfg_wr,
    input  logic        item_valid,
    input  ppc_item_t   item,
    output logic        item_take,
    output logic        empty,
    input  logic        pop,
    output logic        path_valid
);

    // Configuration registers
    logic [MAX_LEN_W-1:0]   max_len_reg;
    logic [MAX_DEPTH_W-1:0] max_depth_reg;

    // Path state
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    stem_t                 stem_reg;
    logic [STEM_LEN_W-1:0] stem_len_reg, stem_len_next;
    logic                  dot_reg, dot_next;
    logic                  space_reg, space_next;
    logic                  disq_reg, disq_next;
    logic [7:0]            prev_reg, prev_next;
    logic                  failed_reg, failed_next;

    // Result queue
    logic       res_mem_reg [2];
    logic       res_wr_ptr_reg, res_rd_ptr_reg;
    logic [1:0] res_count_reg, res_count_next;
    logic       res_push, res_pop, res_full, res_bit;

    // Byte-take intermediates
    logic [COUNT_W:0]      cnt_inc;
    logic                  too_long;
    logic [COUNT_W-1:0]    cnt_sat;
    logic                  stem_wr;
    stem_t                 stem_tk;
    logic [STEM_LEN_W-1:0] len_tk;
    logic                  dot_tk, space_tk, disq_tk;

    // Component-finish intermediates
    logic [COUNT_W-1:0]    f_count;
    logic [7:0]            f_prev;
    stem_t                 f_stem;
    logic [STEM_LEN_W-1:0] f_len;
    logic                  f_disq;
    logic [DEPTH_W-1:0]    depth_inc;
    logic                  finish_fail;
    logic                  fail_in;

    assign res_full  = (res_count_reg == 2'd2);
    assign empty     = (res_count_reg == 2'd0);
    assign path_valid = res_mem_reg[res_rd_ptr_reg];
    assign item_take = item_valid && !res_full;
    assign res_push  = item_take && item.last;
    assign res_pop   = pop && !empty;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            max_depth_reg <= MAX_DEPTH_RESET;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                CFG_MAX_COMPONENT_LENGTH: max_len_reg   <= cfg_wr.data[MAX_LEN_W-1:0];
                CFG_MAX_DEPTH:            max_depth_reg <= cfg_wr.data[MAX_DEPTH_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Non-slash byte: count and stem collection
    always_comb
    begin
        cnt_inc  = {1'b0, count_reg} + {{COUNT_W{1'b0}}, 1'b1};
        too_long = cnt_inc > {1'b0, max_len_reg};
        cnt_sat  = (count_reg < COUNT_MAX) ? cnt_inc[COUNT_W-1:0] : count_reg;
        stem_tk  = stem_reg;
        len_tk   = stem_len_reg;
        dot_tk   = dot_reg;
        space_tk = space_reg;
        disq_tk  = disq_reg;
        stem_wr  = 1'b0;
        if (!dot_reg)
        begin
            if (item.is_dot)
            begin
                dot_tk = 1'b1;
            end
            else if (item.is_space)
            begin
                space_tk = 1'b1;
            end
            else if (space_reg)
            begin
                disq_tk = 1'b1;
            end
            else if (stem_len_reg < STEM_LEN_MAX)
            begin
                stem_wr = 1'b1;
                stem_tk[stem_len_reg[STEM_IDX_W-1:0]] = item.data;
                len_tk  = stem_len_reg + 4'd1;
            end
            else
            begin
                disq_tk = 1'b1;
            end
        end
    end

    // Component finish: on slash uses held state, on a final byte the updated one
    always_comb
    begin
        if (item.is_slash)
        begin
            f_count = count_reg;
            f_prev  = prev_reg;
            f_stem  = stem_reg;
            f_len   = stem_len_reg;
            f_disq  = disq_reg;
        end
        else
        begin
            f_count = cnt_sat;
            f_prev  = item.data;
            f_stem  = stem_tk;
            f_len   = len_tk;
            f_disq  = disq_tk;
        end
        depth_inc   = (depth_reg < DEPTH_MAX) ? depth_reg + 7'd1 : depth_reg;
        finish_fail = (f_count == '0) || (f_prev == CH_DOT) || (f_prev == CH_SPACE) ||
                      (!f_disq && stem_is_device(f_stem, f_len)) ||
                      (depth_inc > {1'b0, max_depth_reg});
        fail_in     = failed_reg || item.is_forbidden;
    end

    // Next state and verdict
    always_comb
    begin
        count_next    = count_reg;
        depth_next    = depth_reg;
        stem_len_next = stem_len_reg;
        dot_next      = dot_reg;
        space_next    = space_reg;
        disq_next     = disq_reg;
        prev_next     = prev_reg;
        failed_next   = failed_reg;
        res_bit       = 1'b0;
        if (item_take)
        begin
            if (item.last)
            begin
                // verdict, then back to the start of a path
                if (item.is_slash)
                begin
                    res_bit = 1'b0;
                end
                else
                begin
                    res_bit = !(fail_in || too_long || finish_fail);
                end
                count_next    = '0;
                depth_next    = '0;
                stem_len_next = '0;
                dot_next      = 1'b0;
                space_next    = 1'b0;
                disq_next     = 1'b0;
                prev_next     = '0;
                failed_next   = 1'b0;
            end
            else if (item.is_slash)
            begin
                failed_next   = fail_in || finish_fail;
                depth_next    = depth_inc;
                count_next    = '0;
                stem_len_next = '0;
                dot_next      = 1'b0;
                space_next    = 1'b0;
                disq_next     = 1'b0;
                prev_next     = item.data;
            end
            else
            begin
                failed_next   = fail_in || too_long;
                count_next    = cnt_sat;
                stem_len_next = len_tk;
                dot_next      = dot_tk;
                space_next    = space_tk;
                disq_next     = disq_tk;
                prev_next     = item.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            depth_reg    <= '0;
            stem_len_reg <= '0;
            dot_reg      <= 1'b0;
            space_reg    <= 1'b0;
            disq_reg     <= 1'b0;
            prev_reg     <= '0;
            failed_reg   <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            depth_reg    <= depth_next;
            stem_len_reg <= stem_len_next;
            dot_reg      <= dot_next;
            space_reg    <= space_next;
            disq_reg     <= disq_next;
            prev_reg     <= prev_next;
            failed_reg   <= failed_next;
        end
    end

    // Stem buffer, no reset; only entries below the stem length are read
    always_ff @(posedge clk)
    begin
        if (item_take && !item.is_slash && !item.last && stem_wr)
        begin
            stem_reg[stem_len_reg[STEM_IDX_W-1:0]] <= item.data;
        end
    end

    // Result queue control
    always_comb
    begin
        case ({res_push, res_pop})
            2'b10:   res_count_next = res_count_reg + 2'd1;
            2'b01:   res_count_next = res_count_reg - 2'd1;
            default: res_count_next = res_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_count_reg  <= 2'd0;
        end
        else
        begin
            if (res_push)
            begin
                res_wr_ptr_reg <= ~res_wr_ptr_reg;
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <= ~res_rd_ptr_reg;
            end
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem_reg[res_wr_ptr_reg] <= res_bit;
        end
    end

endmodule

### hw/rtl/portable_path_checker_top.sv
// Portable path checker. Push a path one byte per item with last_byte set on its
// final byte; one path_valid verdict (1 = portable) is queued after that byte and
// popped from the result side. The block sustains one byte per clock while the
// result queue is not full: a two-entry front queue holds classified bytes, the
// back applies each byte's state update (including the parallel device-name
// compare on component end), and a two-entry result queue lets the output stall
// on its own. A pushed byte is registered in the front queue before the back can
// take it, and a verdict is visible on the result ports in the cycle after the
// back takes its last byte. Registers (index 0 max_component_length, index 1
// max_depth) are written through cfg_valid/cfg_ready, which is always ready;
// write them only while no path is in flight.
module portable_path_checker_top
    import ppc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            path_byte,
    input  logic                  last_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic                  path_valid,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ppc_item_t   item;
    logic        item_valid;
    logic        item_take;
    ppc_cfg_wr_t cfg_wr;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    ppc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .path_byte  (path_byte),
        .last_byte  (last_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    ppc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .empty      (empty),
        .pop        (pop),
        .path_valid (path_valid)
    );

endmodule
